@@ sv/smp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smp_pkg
// Shared types and command codes for the symbolic mode parser.
// ----------------------------------------------------------------------------
package smp_pkg;

  // command codes of an input word
  localparam logic [1:0] CMD_BEGIN  = 2'd0;
  localparam logic [1:0] CMD_CHAR   = 2'd1;
  localparam logic [1:0] CMD_FINISH = 2'd2;

  // one input word as held in the input register
  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  ch;
    logic [11:0] base_mode;
  } smp_item_t;

  // one result word
  typedef struct packed {
    logic [11:0] mode;
    logic        error;
  } smp_res_t;

endpackage
`default_nettype wire

@@ sv/smp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smp_in_if / smp_out_if
// Valid/ready channels carrying input words and result words.
// ----------------------------------------------------------------------------
interface smp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  ch;
  logic [11:0] base_mode;

  modport source (output valid, output command, output ch, output base_mode, input ready);
  modport sink   (input valid, input command, input ch, input base_mode, output ready);
endinterface

interface smp_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] mode;
  logic        error;

  modport source (output valid, output mode, output error, input ready);
  modport sink   (input valid, input mode, input error, output ready);
endinterface
`default_nettype wire

@@ sv/symbolic_mode_parser_unit.sv @@
`default_nettype none
// A finish word is parsed from the input register into the result register.
// One word per cycle is taken while no finish word waits; each word updates the parse state.
// A finish word waits in the input register only while a result word is held.
// Reset clears the parse state to the who phase with a zero mode and empties both registers.
// ----------------------------------------------------------------------------
// symbolic_mode_parser_unit
// Top level: input register, parser, result register with valid/ready channels.
// ----------------------------------------------------------------------------
module symbolic_mode_parser_unit (
  input  wire           clk,
  input  wire           rst_n,
  smp_in_if.sink        in_bus,
  smp_out_if.source     out_bus
);
  import smp_pkg::*;

  logic      s1_valid_r;
  smp_item_t s1_item_r;
  logic      out_valid_r, out_valid_nxt;
  smp_res_t  out_res_r;
  logic      step_en;
  logic      res_valid;
  smp_res_t  res;

  // the held word moves on unless it is a finish facing a full result register
  assign step_en = s1_valid_r &&
                   ((s1_item_r.command != CMD_FINISH) || !out_valid_r || out_bus.ready);
  assign in_bus.ready  = !s1_valid_r || step_en;
  assign out_valid_nxt = res_valid || (out_valid_r && !out_bus.ready);

  // input and result register valid control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_bus.ready) s1_valid_r <= in_bus.valid;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_item_r.command   <= in_bus.command;
      s1_item_r.ch        <= in_bus.ch;
      s1_item_r.base_mode <= in_bus.base_mode;
    end
    if (res_valid) out_res_r <= res;
  end

  smp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  assign out_bus.valid = out_valid_r;
  assign out_bus.mode  = out_res_r.mode;
  assign out_bus.error = out_res_r.error;

`ifndef SYNTHESIS
  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |-> !res_valid)
    else $error("result register overwritten while stalled");

  // only a full input register can hold off the source
  a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> s1_valid_r)
    else $error("input stalled with empty input register");

  // words other than finish never wait
  a_nonfinish_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_item_r.command != CMD_FINISH)) |-> step_en)
    else $error("non-finish word held");

  // an error result carries a zero mode
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.error) |-> (out_res_r.mode == 12'd0))
    else $error("error result with nonzero mode");

  // a result appears in the cycle after a finish word steps
  a_res_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && (s1_item_r.command == CMD_FINISH)) |=> out_valid_r)
    else $error("finish produced no result");
`endif

endmodule
`default_nettype wire

@@ sv/smp_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// smp_parser
// Parse state registers and the per-word next-state logic.
// ----------------------------------------------------------------------------
module smp_parser (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  step_en,
  input  smp_pkg::smp_item_t   item,
  output logic                 res_valid,
  output smp_pkg::smp_res_t    res
);
  import smp_pkg::*;

  typedef enum logic {PH_WHO, PH_PERM} phase_t;
  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_SET} op_t;

  // characters
  localparam logic [7:0] CHR_U     = 8'h75;
  localparam logic [7:0] CHR_G     = 8'h67;
  localparam logic [7:0] CHR_O     = 8'h6f;
  localparam logic [7:0] CHR_A     = 8'h61;
  localparam logic [7:0] CHR_R     = 8'h72;
  localparam logic [7:0] CHR_W     = 8'h77;
  localparam logic [7:0] CHR_X     = 8'h78;
  localparam logic [7:0] CHR_S     = 8'h73;
  localparam logic [7:0] CHR_T     = 8'h74;
  localparam logic [7:0] CHR_PLUS  = 8'h2b;
  localparam logic [7:0] CHR_MINUS = 8'h2d;
  localparam logic [7:0] CHR_EQ    = 8'h3d;
  localparam logic [7:0] CHR_COMMA = 8'h2c;

  // permission masks
  localparam logic [8:0]  WHO_U    = 9'o700;
  localparam logic [8:0]  WHO_G    = 9'o070;
  localparam logic [8:0]  WHO_O    = 9'o007;
  localparam logic [8:0]  WHO_ALL  = 9'o777;
  localparam logic [8:0]  PERM_R   = 9'o444;
  localparam logic [8:0]  PERM_W   = 9'o222;
  localparam logic [8:0]  PERM_X   = 9'o111;
  localparam logic [11:0] BIT_SUID = 12'o4000;
  localparam logic [11:0] BIT_SGID = 12'o2000;
  localparam logic [11:0] BIT_STKY = 12'o1000;
  localparam logic [11:0] SPECIAL  = 12'o7000;

  logic [11:0] running_mode_r, running_mode_nxt;
  logic [8:0]  who_mask_r, who_mask_nxt;
  logic        who_seen_r, who_seen_nxt;
  op_t         op_r, op_nxt;
  phase_t      phase_r, phase_nxt;
  logic        perms_seen_r, perms_seen_nxt;
  logic [11:0] add_bits_r, add_bits_nxt;
  logic [11:0] remove_bits_r, remove_bits_nxt;
  logic        error_r, error_nxt;

  // mode after applying the clause being built
  function automatic logic [11:0] close_clause(
    input logic [11:0] rm,
    input logic [8:0]  who,
    input logic        perms,
    input op_t         op,
    input logic [11:0] addb,
    input logic [11:0] remb
  );
    logic [11:0] w;
    logic [11:0] r;
    w = {3'b000, who};
    if (!perms) begin
      unique case (op)
        OP_ADD:  r = rm | w;
        OP_SUB:  r = rm & ~w;
        default: r = (rm & SPECIAL) | w;
      endcase
    end else if (op == OP_SET) begin
      r = (rm & SPECIAL) | addb;
    end else begin
      r = (rm | addb) & ~remb;
    end
    return r;
  endfunction

  logic        is_who, is_oper, is_perm;
  logic [8:0]  who_bit;
  logic [11:0] perm_bit;
  op_t         ch_op;
  logic [11:0] closed_mode;
  logic        fin_err;

  // character decode
  always_comb begin
    is_who  = (item.ch == CHR_U) || (item.ch == CHR_G) ||
              (item.ch == CHR_O) || (item.ch == CHR_A);
    is_oper = (item.ch == CHR_PLUS) || (item.ch == CHR_MINUS) || (item.ch == CHR_EQ);
    priority if (item.ch == CHR_U) who_bit = WHO_U;
    else if (item.ch == CHR_G)     who_bit = WHO_G;
    else if (item.ch == CHR_O)     who_bit = WHO_O;
    else                           who_bit = WHO_ALL;
    priority if (item.ch == CHR_PLUS) ch_op = OP_ADD;
    else if (item.ch == CHR_MINUS)    ch_op = OP_SUB;
    else                              ch_op = OP_SET;
    is_perm  = 1'b1;
    perm_bit = '0;
    priority if (item.ch == CHR_R) perm_bit = {3'b000, PERM_R & who_mask_r};
    else if (item.ch == CHR_W)     perm_bit = {3'b000, PERM_W & who_mask_r};
    else if (item.ch == CHR_X)     perm_bit = {3'b000, PERM_X & who_mask_r};
    else if (item.ch == CHR_S)
      perm_bit = ((|(who_mask_r & WHO_U)) ? BIT_SUID : 12'd0) |
                 ((|(who_mask_r & WHO_G)) ? BIT_SGID : 12'd0);
    else if (item.ch == CHR_T)     perm_bit = BIT_STKY;
    else                           is_perm = 1'b0;
    closed_mode = close_clause(running_mode_r, who_mask_r, perms_seen_r, op_r,
                               add_bits_r, remove_bits_r);
  end

  // next state for the word in the input register
  always_comb begin
    running_mode_nxt = running_mode_r;
    who_mask_nxt     = who_mask_r;
    who_seen_nxt     = who_seen_r;
    op_nxt           = op_r;
    phase_nxt        = phase_r;
    perms_seen_nxt   = perms_seen_r;
    add_bits_nxt     = add_bits_r;
    remove_bits_nxt  = remove_bits_r;
    error_nxt        = error_r;
    fin_err          = error_r;
    res_valid        = 1'b0;
    res.mode         = '0;
    res.error        = 1'b0;
    if (step_en) begin
      unique case (item.command)
        CMD_BEGIN: begin
          running_mode_nxt = item.base_mode;
          error_nxt        = 1'b0;
          who_mask_nxt     = '0;
          who_seen_nxt     = 1'b0;
          op_nxt           = OP_ADD;
          phase_nxt        = PH_WHO;
          perms_seen_nxt   = 1'b0;
          add_bits_nxt     = '0;
          remove_bits_nxt  = '0;
        end
        CMD_CHAR: begin
          if (!error_r) begin
            if (phase_r == PH_WHO) begin
              if (is_who) begin
                who_seen_nxt = 1'b1;
                who_mask_nxt = who_mask_r | who_bit;
              end else if (is_oper) begin
                if (!who_seen_r) who_mask_nxt = WHO_ALL;
                op_nxt          = ch_op;
                phase_nxt       = PH_PERM;
                perms_seen_nxt  = 1'b0;
                add_bits_nxt    = '0;
                remove_bits_nxt = '0;
              end else begin
                error_nxt = 1'b1;
              end
            end else begin
              if (item.ch == CHR_COMMA) begin
                running_mode_nxt = closed_mode;
                who_mask_nxt     = '0;
                who_seen_nxt     = 1'b0;
                op_nxt           = OP_ADD;
                phase_nxt        = PH_WHO;
                perms_seen_nxt   = 1'b0;
                add_bits_nxt     = '0;
                remove_bits_nxt  = '0;
              end else if (is_oper) begin
                // next operator opens a clause with the default who
                running_mode_nxt = closed_mode;
                who_mask_nxt     = WHO_ALL;
                who_seen_nxt     = 1'b0;
                op_nxt           = ch_op;
                perms_seen_nxt   = 1'b0;
                add_bits_nxt     = '0;
                remove_bits_nxt  = '0;
              end else if (is_perm) begin
                perms_seen_nxt = 1'b1;
                if (op_r == OP_SUB) remove_bits_nxt = remove_bits_r | perm_bit;
                else                add_bits_nxt    = add_bits_r | perm_bit;
              end else begin
                error_nxt = 1'b1;
              end
            end
          end
        end
        CMD_FINISH: begin
          if (!error_r) begin
            if (phase_r == PH_PERM) running_mode_nxt = closed_mode;
            else if (who_seen_r)    fin_err = 1'b1;
          end
          res_valid       = 1'b1;
          res.mode        = fin_err ? 12'd0 : running_mode_nxt;
          res.error       = fin_err;
          error_nxt       = 1'b0;
          who_mask_nxt    = '0;
          who_seen_nxt    = 1'b0;
          op_nxt          = OP_ADD;
          phase_nxt       = PH_WHO;
          perms_seen_nxt  = 1'b0;
          add_bits_nxt    = '0;
          remove_bits_nxt = '0;
        end
        default: begin
          // unused command leaves everything as it is
        end
      endcase
    end
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_mode_r <= '0;
      who_mask_r     <= '0;
      who_seen_r     <= 1'b0;
      op_r           <= OP_ADD;
      phase_r        <= PH_WHO;
      perms_seen_r   <= 1'b0;
      add_bits_r     <= '0;
      remove_bits_r  <= '0;
      error_r        <= 1'b0;
    end else begin
      running_mode_r <= running_mode_nxt;
      who_mask_r     <= who_mask_nxt;
      who_seen_r     <= who_seen_nxt;
      op_r           <= op_nxt;
      phase_r        <= phase_nxt;
      perms_seen_r   <= perms_seen_nxt;
      add_bits_r     <= add_bits_nxt;
      remove_bits_r  <= remove_bits_nxt;
      error_r        <= error_nxt;
    end
  end

endmodule
`default_nettype wire
